FILE: sv/euler_transform_builder_defines.svh
// Assertion macros shared by the Euler transform builder RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef EULER_TRANSFORM_BUILDER_DEFINES_SVH
`define EULER_TRANSFORM_BUILDER_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define ETB_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain invariant checked at every rising edge outside reset.
`define ETB_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

FILE: sv/etb_pkg.sv
// Shared constants and the CORDIC arctangent table of the Euler transform builder.
// No dependencies.
package etb_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int CORDIC_ITERS = 28;
	localparam int CORDIC_FRAC  = 30;
	localparam int CORDIC_W     = 34;
	localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// Register indexes of the configuration port.
	localparam logic REG_TOLERANCE = 1'b0;

	// Arctangent of 2^-i in units of 2^32 per full turn.
	function automatic logic signed [CORDIC_W-1:0] atan_turns(input int i);
		logic signed [CORDIC_W-1:0] v;
		case (i)
			0: v = 34'sh020000000;
			1: v = 34'sh012E4051E;
			2: v = 34'sh009FB385B;
			3: v = 34'sh0051111D4;
			4: v = 34'sh0028B0D43;
			5: v = 34'sh00145D7E1;
			6: v = 34'sh000A2F61E;
			7: v = 34'sh000517C55;
			8: v = 34'sh00028BE53;
			9: v = 34'sh000145F2F;
			10: v = 34'sh0000A2F98;
			11: v = 34'sh0000517CC;
			12: v = 34'sh000028BE6;
			13: v = 34'sh0000145F3;
			14: v = 34'sh00000A2F9;
			15: v = 34'sh00000517C;
			16: v = 34'sh0000028BE;
			17: v = 34'sh00000145F;
			18: v = 34'sh000000A2F;
			19: v = 34'sh000000517;
			20: v = 34'sh00000028B;
			21: v = 34'sh000000145;
			22: v = 34'sh0000000A2;
			23: v = 34'sh000000051;
			24: v = 34'sh000000028;
			25: v = 34'sh000000014;
			26: v = 34'sh00000000A;
			27: v = 34'sh000000005;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/etb_if.sv
// Request and result channels of the Euler transform builder.
// No dependencies.
interface etb_req_if;
	logic               valid;
	logic               ready;
	logic [15:0]        angle_phi;
	logic [15:0]        angle_theta;
	logic [15:0]        angle_psi;
	logic signed [31:0] trans_x;
	logic signed [31:0] trans_y;
	logic signed [31:0] trans_z;
	modport source (output valid, angle_phi, angle_theta, angle_psi, trans_x, trans_y, trans_z,
		input ready);
	modport sink (input valid, angle_phi, angle_theta, angle_psi, trans_x, trans_y, trans_z,
		output ready);
endinterface

interface etb_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] m_xx;
	logic signed [17:0] m_yx;
	logic signed [17:0] m_zx;
	logic signed [17:0] m_xy;
	logic signed [17:0] m_yy;
	logic signed [17:0] m_zy;
	logic signed [17:0] m_xz;
	logic signed [17:0] m_yz;
	logic signed [17:0] m_zz;
	logic               has_translation;
	logic               has_rotation;
	logic               is_identity;
	modport source (output valid, m_xx, m_yx, m_zx, m_xy, m_yy, m_zy, m_xz, m_yz, m_zz,
		has_translation, has_rotation, is_identity, input ready);
	modport sink (input valid, m_xx, m_yx, m_zx, m_xy, m_yy, m_zy, m_xz, m_yz, m_zz,
		has_translation, has_rotation, is_identity, output ready);
endinterface

FILE: sv/etb_cordic.sv
// Pipelined CORDIC giving sine and cosine of a binary angle, one iteration per stage.
// Depends on etb_pkg.
module etb_cordic #(
	parameter int ANGLE_BITS = etb_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = etb_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       ce,
	input  logic [ANGLE_BITS-1:0]      angle,
	output logic signed [FRAC_BITS+2:0] sin_val,
	output logic signed [FRAC_BITS+2:0] cos_val
);
	localparam int CW = etb_pkg::CORDIC_W;
	localparam int N  = etb_pkg::CORDIC_ITERS;
	localparam int W  = FRAC_BITS + 3;
	localparam int S  = etb_pkg::CORDIC_FRAC - FRAC_BITS;
	localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FRAC_BITS;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];
	logic                 neg_s [0:N];

	logic [31:0] u;
	logic        fold;
	assign u    = {angle, (32-ANGLE_BITS)'(0)};
	assign fold = 1'(((u + 32'h4000_0000) >> 31));

	// Angles in the left half plane are turned by half a turn and negated at the end.
	always_ff @(posedge clk) begin
		if (ce) begin
			x_s[0]   <= etb_pkg::CORDIC_GAIN;
			y_s[0]   <= '0;
			z_s[0]   <= CW'($signed(u ^ {fold, 31'b0}));
			neg_s[0] <= fold;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (ce) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - etb_pkg::atan_turns(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + etb_pkg::atan_turns(i);
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	function automatic logic signed [W-1:0] to_frac(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		if (S == 0) begin
			r = v;
		end else begin
			r = (v + (CW'(1) <<< (S > 0 ? S - 1 : 0))) >>> S;
		end
		if (r > ONE_C) begin
			r = ONE_C;
		end else if (r < -ONE_C) begin
			r = -ONE_C;
		end
		return W'(r);
	endfunction

	logic signed [CW-1:0] xf, yf;
	assign xf = neg_s[N] ? -x_s[N] : x_s[N];
	assign yf = neg_s[N] ? -y_s[N] : y_s[N];

	always_ff @(posedge clk) begin
		if (ce) begin
			sin_val <= to_frac(yf);
			cos_val <= to_frac(xf);
		end
	end
endmodule

FILE: sv/euler_transform_builder.sv
// Euler z-x-z transform builder. Three binary angles (a full turn is 2^ANGLE_BITS) and a
// Q16.16 translation go in; nine rotation matrix entries with FRAC_BITS fraction bits and
// three tolerance flags come out. The block accepts one request every cycle while the
// result side does not stall and is fully pipelined: a request passes through the CORDIC
// input register, its 28 iteration stages and its rounding register, two product stages,
// a sum stage and the flag/output stage. The whole pipeline advances on one enable, so a
// stall at the result side holds every stage and backs up to req.ready. Depends on etb_pkg,
// etb_if.sv, etb_cordic and euler_transform_builder_defines.svh.
`include "euler_transform_builder_defines.svh"

module euler_transform_builder #(
	parameter int ANGLE_BITS = etb_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = etb_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	etb_req_if.sink     req,
	etb_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int L   = etb_pkg::CORDIC_LAT;
	localparam int LAT = L + 4;
	localparam int W   = FRAC_BITS + 3;
	localparam int DW  = (W + 1 > 17) ? W + 1 : 17;
	localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

	// Configuration: one tolerance register, word aligned.
	logic [15:0] tolerance_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == etb_pkg::REG_TOLERANCE) begin
			tolerance_q <= pwdata[15:0];
		end
	end
	assign prdata = (paddr[2] == etb_pkg::REG_TOLERANCE) ? {16'b0, tolerance_q} : '0;

	// One enable for every stage: move whenever the output register is free or drains.
	logic ce;
	assign ce        = !rsp.valid || rsp.ready;
	assign req.ready = ce;

	logic [LAT:1] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[LAT-1:1], req.valid};
		end
	end
	assign rsp.valid = vld_s[LAT];

	// Sine and cosine of the three angles.
	logic signed [W-1:0] sph, cph, sth, cth, sps, cps;
	etb_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic_phi (
		.clk(clk), .ce(ce), .angle(ANGLE_BITS'(req.angle_phi)), .sin_val(sph), .cos_val(cph));
	etb_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic_the (
		.clk(clk), .ce(ce), .angle(ANGLE_BITS'(req.angle_theta)), .sin_val(sth), .cos_val(cth));
	etb_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic_psi (
		.clk(clk), .ce(ce), .angle(ANGLE_BITS'(req.angle_psi)), .sin_val(sps), .cos_val(cps));

	// The translation rides along until the flag stage.
	logic signed [31:0] tx_s [1:L+3];
	logic signed [31:0] ty_s [1:L+3];
	logic signed [31:0] tz_s [1:L+3];
	always_ff @(posedge clk) begin
		if (ce) begin
			tx_s[1] <= req.trans_x;
			ty_s[1] <= req.trans_y;
			tz_s[1] <= req.trans_z;
			for (int k = 2; k <= L + 3; k++) begin
				tx_s[k] <= tx_s[k-1];
				ty_s[k] <= ty_s[k-1];
				tz_s[k] <= tz_s[k-1];
			end
		end
	end

	// Fixed-point product rounded half up to FRAC_BITS.
	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = (2*W)'(a) * (2*W)'(b) + ((2*W)'(1) <<< (FRAC_BITS - 1));
		return W'(p >>> FRAC_BITS);
	endfunction

	function automatic logic signed [W-1:0] sat_unit(input logic signed [W:0] v);
		logic signed [W:0] r;
		r = v;
		if (v > (W+1)'(ONE)) begin
			r = (W+1)'(ONE);
		end else if (v < -(W+1)'(ONE)) begin
			r = -(W+1)'(ONE);
		end
		return W'(r);
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	function automatic logic [32:0] tmag(input logic signed [31:0] v);
		logic signed [32:0] e;
		e = 33'(v);
		return e[32] ? 33'(-e) : 33'(e);
	endfunction

	// First product stage: the products of two sines or cosines, with the psi terms and cos theta carried along.
	logic signed [W-1:0] ts_s1, tc_s1, cc_s1, sc_s1, zx_s1, cs_s1, ss_s1, zy_s1, xz_s1, yz_s1;
	logic signed [W-1:0] sps_s1, cps_s1, cth_s1;
	always_ff @(posedge clk) begin
		if (ce) begin
			ts_s1  <= fmul(cth, sph);
			tc_s1  <= fmul(cth, cph);
			cc_s1  <= fmul(cps, cph);
			sc_s1  <= fmul(sps, cph);
			zx_s1  <= fmul(sth, sph);
			cs_s1  <= fmul(cps, sph);
			ss_s1  <= fmul(sps, sph);
			zy_s1  <= fmul(sth, cph);
			xz_s1  <= fmul(sps, sth);
			yz_s1  <= fmul(cps, sth);
			sps_s1 <= sps;
			cps_s1 <= cps;
			cth_s1 <= cth;
		end
	end

	// Second product stage: the theta-weighted terms times the psi terms.
	logic signed [W-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [W-1:0] cc_s2, sc_s2, zx_s2, cs_s2, ss_s2, zy_s2, xz_s2, yz_s2, cth_s2;
	always_ff @(posedge clk) begin
		if (ce) begin
			a_s2   <= fmul(ts_s1, sps_s1);
			b_s2   <= fmul(ts_s1, cps_s1);
			c_s2   <= fmul(tc_s1, sps_s1);
			d_s2   <= fmul(tc_s1, cps_s1);
			cc_s2  <= cc_s1;
			sc_s2  <= sc_s1;
			zx_s2  <= zx_s1;
			cs_s2  <= cs_s1;
			ss_s2  <= ss_s1;
			zy_s2  <= zy_s1;
			xz_s2  <= xz_s1;
			yz_s2  <= yz_s1;
			cth_s2 <= cth_s1;
		end
	end

	// Sum stage: the nine entries, each saturated to plus or minus one.
	logic signed [W-1:0] m_s3 [0:8];
	always_ff @(posedge clk) begin
		if (ce) begin
			m_s3[0] <= sat_unit((W+1)'(cc_s2) - (W+1)'(a_s2));
			m_s3[1] <= sat_unit(-(W+1)'(sc_s2) - (W+1)'(b_s2));
			m_s3[2] <= sat_unit((W+1)'(zx_s2));
			m_s3[3] <= sat_unit((W+1)'(cs_s2) + (W+1)'(c_s2));
			m_s3[4] <= sat_unit(-(W+1)'(ss_s2) + (W+1)'(d_s2));
			m_s3[5] <= sat_unit(-(W+1)'(zy_s2));
			m_s3[6] <= sat_unit((W+1)'(xz_s2));
			m_s3[7] <= sat_unit((W+1)'(yz_s2));
			m_s3[8] <= sat_unit((W+1)'(cth_s2));
		end
	end

	// Flag stage: distance from identity and translation size against the tolerance.
	logic htr, hrot;
	always_comb begin
		logic signed [DW-1:0] d;
		htr = (tmag(tx_s[L+3]) > 33'(tolerance_q)) || (tmag(ty_s[L+3]) > 33'(tolerance_q))
			|| (tmag(tz_s[L+3]) > 33'(tolerance_q));
		hrot = 1'b0;
		for (int k = 0; k < 9; k++) begin
			d = DW'(m_s3[k]);
			if (k == 0 || k == 4 || k == 8) begin
				d = d - DW'(ONE);
			end
			if (mag(d) > DW'(tolerance_q)) begin
				hrot = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rsp.m_xx            <= 18'(m_s3[0]);
			rsp.m_yx            <= 18'(m_s3[1]);
			rsp.m_zx            <= 18'(m_s3[2]);
			rsp.m_xy            <= 18'(m_s3[3]);
			rsp.m_yy            <= 18'(m_s3[4]);
			rsp.m_zy            <= 18'(m_s3[5]);
			rsp.m_xz            <= 18'(m_s3[6]);
			rsp.m_yz            <= 18'(m_s3[7]);
			rsp.m_zz            <= 18'(m_s3[8]);
			rsp.has_translation <= htr;
			rsp.has_rotation    <= hrot;
			rsp.is_identity     <= !htr && !hrot;
		end
	end

	// A held result freezes every stage and the request side.
	`ETB_CHECK(a_stall_holds, !ce |=> $stable(vld_s), "pipeline moved while stalled")
	`ETB_CHECK(a_backpressure, rsp.valid && !rsp.ready |-> !req.ready, "request taken during stall")
	`ETB_CHECK(a_flags, rsp.valid |-> rsp.is_identity != (rsp.has_translation || rsp.has_rotation),
		"identity flag disagrees with the other flags")
endmodule
